### rtl/lsq_pkg.sv
// Shared constants, types and helper functions for the segment-to-quad expander.
// Used by lsq_sqrt, lsq_div, line_segment_to_quad, lsq_checker and the testbench; depends on nothing else.
`default_nettype none
package lsq_pkg;

  // Fraction bits of world coordinates and of the degree inputs.
  localparam int COORD_FRAC_BITS = 16;
  localparam int DEG_FRAC        = 22;
  localparam int SH_R = (DEG_FRAC > COORD_FRAC_BITS) ? DEG_FRAC - COORD_FRAC_BITS : 0;
  localparam int SH_L = (COORD_FRAC_BITS > DEG_FRAC) ? COORD_FRAC_BITS - DEG_FRAC : 0;

  // Datapath widths.
  localparam int CW   = 32;                  // coordinate field width
  localparam int DW0  = CW + 1;              // centred coordinate
  localparam int PRW  = 49;                  // centred coordinate times scale
  localparam int WW   = PRW - SH_R + SH_L;   // world x
  localparam int ZW   = WW + 1;              // world z (negated)
  localparam int DDW  = WW + 2;              // dx, dz
  localparam int AW   = DDW - 1;             // |dx|, |dz|
  localparam int PSW  = $clog2(AW);          // leading one position
  localparam int NB   = 30;                  // normalised magnitude width
  localparam int SQW  = 2 * NB + 1;          // sum of squares
  localparam int RB   = NB + 1;              // square root width
  localparam int HW   = 24;                  // half width register
  localparam int NUMW = NB + HW + 1;         // divider numerator
  localparam int QB   = HW + 1;              // offset magnitude
  localparam int SUMW = WW + 3;              // vertex before saturation

  // Short segment threshold on the exact squared length.
  localparam longint LIMIT = longint'(((64'd1 << (2 * COORD_FRAC_BITS)) - 64'd1) / 100000000);
  localparam int SB = ($clog2(LIMIT + 1) + 1) / 2 + 1;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_CENTER_LON = 2'd0;
  localparam logic [1:0] REG_CENTER_LAT = 2'd1;
  localparam logic [1:0] REG_MAP_SCALE  = 2'd2;
  localparam logic [1:0] REG_HALF_WIDTH = 2'd3;
  localparam logic [15:0] SCALE_RESET = 16'd20000;
  localparam logic [HW-1:0] HALF_WIDTH_RESET = 24'd26214;

  // Vertex emission order c1,c2,c3,c2,c4,c3.
  localparam logic [2:0] LAST_VTX = 3'd5;

  function automatic logic [1:0] vert_sel(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd3;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Clamp to the signed 32 bit range.
  function automatic logic [CW-1:0] sat32(input logic signed [SUMW-1:0] v);
    logic [CW-1:0] r;
    if (v > SUMW'(signed'(32'sh7fffffff)))       r = 32'h7fffffff;
    else if (v < SUMW'(signed'(-33'sh80000000))) r = 32'h80000000;
    else                                         r = v[CW-1:0];
    return r;
  endfunction

  // Payload that travels beside the length and offset arithmetic.
  typedef struct packed {
    logic signed [WW-1:0] x1;
    logic signed [WW-1:0] x2;
    logic signed [ZW-1:0] z1;
    logic signed [ZW-1:0] z2;
    logic                 ndx;
    logic                 ndz;
    logic [NB-1:0]        nax;
    logic [NB-1:0]        naz;
  } side_t;

endpackage
`default_nettype wire

### rtl/lsq_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on lsq_pkg for its widths.
`default_nettype none
module lsq_sqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [lsq_pkg::SQW-1:0]      v,
  output logic      [lsq_pkg::RB-1:0]       root
);
  localparam int RW = 2 * lsq_pkg::RB + 1;

  logic [RW-1:0]          rem [0:lsq_pkg::RB];
  logic [lsq_pkg::RB-1:0] q   [0:lsq_pkg::RB];

  assign rem[0] = RW'(v);
  assign q[0]   = '0;

  // Each stage tries the next lower root bit against the remainder.
  for (genvar i = 0; i < lsq_pkg::RB; i++) begin : g_stage
    localparam int B = lsq_pkg::RB - 1 - i;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = (RW'(q[i]) << (B + 1)) + (RW'(1) << (2 * B));
    assign ge    = rem[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? rem[i] - trial : rem[i];
        q[i+1]   <= ge ? (q[i] | (lsq_pkg::RB'(1) << B)) : q[i];
      end
    end
  end

  assign root = q[lsq_pkg::RB];
endmodule
`default_nettype wire

### rtl/lsq_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on lsq_pkg; the numerator must be below den * 2^QB.
`default_nettype none
module lsq_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [lsq_pkg::NUMW-1:0]  num,
  input  wire logic [lsq_pkg::RB-1:0]    den,
  output logic      [lsq_pkg::QB-1:0]    quo
);
  localparam int NW = lsq_pkg::NUMW;
  localparam int QB = lsq_pkg::QB;

  logic [NW-1:0]          rem [0:QB];
  logic [lsq_pkg::RB-1:0] d   [0:QB];
  logic [QB-1:0]          q   [0:QB];

  assign rem[0] = num;
  assign d[0]   = den;
  assign q[0]   = '0;

  // Each stage subtracts the shifted divisor when it fits.
  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int B = QB - 1 - i;
    logic [NW-1:0] sub;
    logic          ge;
    assign sub = NW'(d[i]) << B;
    assign ge  = rem[i] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? rem[i] - sub : rem[i];
        q[i+1]   <= ge ? (q[i] | (QB'(1) << B)) : q[i];
        d[i+1]   <= d[i];
      end
    end
  end

  assign quo = q[QB];
endmodule
`default_nettype wire

### rtl/line_segment_to_quad.sv
// Segment to quad expander: one segment in, six vertices out as two triangles.
// A segment can enter every cycle unless the output stage is full and blocked; the
// output gives one vertex a cycle while m_axis_tready is high and sets a stream's rate.
// Short segments leave no vertices. Reset (rst, synchronous) empties the pipeline and
// loads the configuration defaults. Depends on lsq_pkg, lsq_sqrt and lsq_div.
`default_nettype none
module line_segment_to_quad (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_lon[31:0], start_lat[63:32], end_lon[95:64], end_lat[127:96]
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // vert_x[31:0], vert_z[63:32]
  output logic [63:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  localparam int WW   = lsq_pkg::WW;
  localparam int ZW   = lsq_pkg::ZW;
  localparam int DDW  = lsq_pkg::DDW;
  localparam int AW   = lsq_pkg::AW;
  localparam int PRW  = lsq_pkg::PRW;
  localparam int NB   = lsq_pkg::NB;
  localparam int RB   = lsq_pkg::RB;
  localparam int QB   = lsq_pkg::QB;
  localparam int SB   = lsq_pkg::SB;
  localparam int SUMW = lsq_pkg::SUMW;
  localparam int SQI  = 4 + RB;          // side index at the root output
  localparam int NS   = 6 + RB + QB;     // side index at the quotient output

  // Configuration registers.
  logic signed [31:0]       center_lon;
  logic signed [31:0]       center_lat;
  logic [15:0]              map_scale;
  logic [lsq_pkg::HW-1:0]   half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_lon <= '0;
      center_lat <= '0;
      map_scale  <= lsq_pkg::SCALE_RESET;
      half_width <= lsq_pkg::HALF_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lsq_pkg::REG_CENTER_LON: center_lon <= cfg_data;
        lsq_pkg::REG_CENTER_LAT: center_lat <= cfg_data;
        lsq_pkg::REG_MAP_SCALE:  map_scale  <= cfg_data[15:0];
        default:                 half_width <= cfg_data[lsq_pkg::HW-1:0];
      endcase
    end
  end

  // Global advance: everything moves unless the output stage is full and blocked.
  logic en;
  logic ov;
  logic load;
  assign en = !ov || load;
  assign s_axis_tready = en;

  // Stage 1: centre the four coordinates.
  logic signed [lsq_pkg::DW0-1:0] d1 [4];
  logic                           v1;
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})   - $signed({center_lon[31], center_lon});
      d1[1] <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]})  - $signed({center_lat[31], center_lat});
      d1[2] <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]})  - $signed({center_lon[31], center_lon});
      d1[3] <= $signed({s_axis_tdata[127], s_axis_tdata[127:96]}) - $signed({center_lat[31], center_lat});
    end
  end

  // Stage 2: multiply by the map scale.
  logic signed [PRW-1:0] p2 [4];
  logic                  v2;
  for (genvar j = 0; j < 4; j++) begin : g_scale
    logic signed [lsq_pkg::DW0+16:0] prod;
    assign prod = d1[j] * $signed({1'b0, map_scale});
    always_ff @(posedge clk) begin
      if (en) p2[j] <= prod[PRW-1:0];
    end
  end

  // Stage 3: bring to world fraction bits, rounding to nearest with ties upward.
  logic signed [WW-1:0] w2 [4];
  for (genvar j = 0; j < 4; j++) begin : g_round
    if (lsq_pkg::SH_R > 0) begin : g_rs
      logic signed [PRW:0] rnd;
      assign rnd   = {p2[j][PRW-1], p2[j]} + ((PRW + 1)'(1) << (lsq_pkg::SH_R - 1));
      assign w2[j] = WW'(rnd >>> lsq_pkg::SH_R);
    end else begin : g_ls
      assign w2[j] = WW'(p2[j]) <<< lsq_pkg::SH_L;
    end
  end

  logic signed [WW-1:0] x1_3, x2_3;
  logic signed [ZW-1:0] z1_3, z2_3;
  logic                 v3;
  always_ff @(posedge clk) begin
    if (en) begin
      x1_3 <= w2[0];
      z1_3 <= -{w2[1][WW-1], w2[1]};
      x2_3 <= w2[2];
      z2_3 <= -{w2[3][WW-1], w2[3]};
    end
  end

  // Stage 4: segment deltas.
  logic signed [DDW-1:0] dx4, dz4;
  logic signed [WW-1:0]  x1_4, x2_4;
  logic signed [ZW-1:0]  z1_4, z2_4;
  logic                  v4;
  always_ff @(posedge clk) begin
    if (en) begin
      dx4  <= DDW'(x2_3) - DDW'(x1_3);
      dz4  <= DDW'(z2_3) - DDW'(z1_3);
      x1_4 <= x1_3;
      x2_4 <= x2_3;
      z1_4 <= z1_3;
      z2_4 <= z2_3;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Side chain from stage 5 to the quotient output.
  lsq_pkg::side_t side [0:NS];
  logic [NS:0]    sv;

  // Stage 5 (side 0): magnitudes and signs.
  logic [AW-1:0] ax5, az5;
  logic [DDW-1:0] adx, adz;
  assign adx = dx4[DDW-1] ? -dx4 : dx4;
  assign adz = dz4[DDW-1] ? -dz4 : dz4;

  // Stage 6 (side 1): short segment test and leading one of max(|dx|,|dz|).
  logic [AW-1:0]           orv;
  logic [lsq_pkg::PSW-1:0] lead;
  logic [2*SB:0]           small_sq;
  logic                    is_short;
  always_comb begin
    orv  = ax5 | az5;
    lead = '0;
    for (int i = 0; i < AW; i++) begin
      if (orv[i]) lead = lsq_pkg::PSW'(i);
    end
    small_sq = (2*SB+1)'(ax5[SB-1:0] * ax5[SB-1:0]) + (2*SB+1)'(az5[SB-1:0] * az5[SB-1:0]);
    is_short = ((ax5 >> SB) == '0) && ((az5 >> SB) == '0)
               && (64'(small_sq) <= 64'(lsq_pkg::LIMIT));
  end

  logic [AW-1:0]           ax6, az6;
  logic [lsq_pkg::PSW-1:0] p6;

  // Stage 7 (side 2): normalise so the larger magnitude sits in [2^29, 2^30).
  logic [AW-1:0]  nx_w, nz_w;
  lsq_pkg::side_t s2_next;
  always_comb begin
    if (p6 > lsq_pkg::PSW'(NB - 1)) begin
      nx_w = ax6 >> (p6 - lsq_pkg::PSW'(NB - 1));
      nz_w = az6 >> (p6 - lsq_pkg::PSW'(NB - 1));
    end else begin
      nx_w = ax6 << (lsq_pkg::PSW'(NB - 1) - p6);
      nz_w = az6 << (lsq_pkg::PSW'(NB - 1) - p6);
    end
    s2_next     = side[1];
    s2_next.nax = nx_w[NB-1:0];
    s2_next.naz = nz_w[NB-1:0];
  end

  // Stages 8 and 9 (side 3, 4): squares, then their sum.
  logic [2*NB-1:0]         sqx8, sqz8;
  logic [lsq_pkg::SQW-1:0] sum9;

  // Offset numerators after the root.
  logic [RB-1:0]             len;
  logic [NB+lsq_pkg::HW-1:0] px41, pz41;
  logic [RB-1:0]             len41;
  logic [lsq_pkg::NUMW-1:0]  numx42, numz42;
  logic [RB-1:0]             den42;

  always_ff @(posedge clk) begin
    if (en) begin
      ax5 <= adx[AW-1:0];
      az5 <= adz[AW-1:0];
      side[0].x1  <= x1_4;
      side[0].x2  <= x2_4;
      side[0].z1  <= z1_4;
      side[0].z2  <= z2_4;
      side[0].ndx <= dx4[DDW-1];
      side[0].ndz <= dz4[DDW-1];
      side[0].nax <= '0;
      side[0].naz <= '0;
      for (int k = 1; k <= NS; k++) side[k] <= (k == 2) ? s2_next : side[k-1];
      ax6 <= ax5;
      az6 <= az5;
      p6  <= lead;
      sqx8 <= side[2].nax * side[2].nax;
      sqz8 <= side[2].naz * side[2].naz;
      sum9 <= lsq_pkg::SQW'(sqx8) + lsq_pkg::SQW'(sqz8);
      px41  <= side[SQI].nax * half_width;
      pz41  <= side[SQI].naz * half_width;
      len41 <= len;
      numx42 <= lsq_pkg::NUMW'(pz41) + lsq_pkg::NUMW'(len41 >> 1);
      numz42 <= lsq_pkg::NUMW'(px41) + lsq_pkg::NUMW'(len41 >> 1);
      den42  <= len41;
    end
  end

  // Side valid bits; a short segment is dropped at stage 6.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[NS-1:1], sv[0] && !is_short, v4};
    end
  end

  lsq_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (sum9),
    .root (len)
  );

  logic [QB-1:0] qx, qz;

  lsq_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx42),
    .den (den42),
    .quo (qx)
  );

  lsq_div u_div_z (
    .clk (clk),
    .en  (en),
    .num (numz42),
    .den (den42),
    .quo (qz)
  );

  // Output stage: offset both ends along the perpendicular and saturate.
  logic signed [SUMW-1:0] ox, oz;
  logic [31:0]            vx_n [4];
  logic [31:0]            vz_n [4];
  always_comb begin
    ox = side[NS].ndz ? SUMW'($signed({1'b0, qx})) : -SUMW'($signed({1'b0, qx}));
    oz = side[NS].ndx ? -SUMW'($signed({1'b0, qz})) : SUMW'($signed({1'b0, qz}));
    vx_n[0] = lsq_pkg::sat32(SUMW'(side[NS].x1) + ox);
    vz_n[0] = lsq_pkg::sat32(SUMW'(side[NS].z1) + oz);
    vx_n[1] = lsq_pkg::sat32(SUMW'(side[NS].x1) - ox);
    vz_n[1] = lsq_pkg::sat32(SUMW'(side[NS].z1) - oz);
    vx_n[2] = lsq_pkg::sat32(SUMW'(side[NS].x2) + ox);
    vz_n[2] = lsq_pkg::sat32(SUMW'(side[NS].z2) + oz);
    vx_n[3] = lsq_pkg::sat32(SUMW'(side[NS].x2) - ox);
    vz_n[3] = lsq_pkg::sat32(SUMW'(side[NS].z2) - oz);
  end

  logic [31:0] ovx [4];
  logic [31:0] ovz [4];
  always_ff @(posedge clk) begin
    if (en) begin
      ovx <= vx_n;
      ovz <= vz_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= sv[NS];
  end

  // Vertex sequencer: holds one quad and sends its six vertices.
  logic        busy;
  logic [2:0]  cnt;
  logic [31:0] hvx [4];
  logic [31:0] hvz [4];
  logic [1:0]  sel;

  assign load = ov && (!busy || (cnt == lsq_pkg::LAST_VTX && m_axis_tready));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && m_axis_tready) begin
      if (cnt == lsq_pkg::LAST_VTX) busy <= 1'b0;
      else cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hvx <= ovx;
      hvz <= ovz;
    end
  end

  assign sel           = lsq_pkg::vert_sel(cnt);
  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {hvz[sel], hvx[sel]};
  assign m_axis_tlast  = busy && (cnt == lsq_pkg::LAST_VTX);

  // Checks on the sequencer and the output stage.
  a_last_in_seq: assert property (@(posedge clk) disable iff (rst)
    m_axis_tlast |-> (m_axis_tvalid && cnt == lsq_pkg::LAST_VTX))
    else $error("last flag outside the sixth vertex");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !m_axis_tready) |=> ($stable(cnt) && busy))
    else $error("vertex counter moved while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (ov && !load) |=> (ov && busy))
    else $error("output stage lost a quad while blocked");

endmodule
`default_nettype wire

### dv/lsq_checker.sv
// Checker for the segment-to-quad expander: watches the configuration port and both streams.
// It predicts the six vertices of each segment above the minimum length and compares them in order.
// Depends on lsq_pkg.
`default_nettype none
module lsq_checker
  import lsq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [63:0]  m_axis_tdata,
  input  wire logic         m_axis_tlast,
  output int                fail_count,
  output int                vertices_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vz;
    logic        last;
  } vertex_t;

  // Shadow copy of the configuration registers.
  logic signed [31:0] ctr_lon, ctr_lat;
  logic [15:0]        scale;
  logic [23:0]        half_w;

  vertex_t quad_vertex_q[$];

  // Degrees to world units, rounded to nearest with ties upward.
  function automatic longint to_world_units(logic [31:0] c, logic signed [31:0] ctr,
                                            logic [15:0] sc);
    longint p;
    p = (longint'($signed(c)) - longint'(ctr)) * longint'(sc);
    if (SH_R > 0)
      return (p + (longint'(1) <<< (SH_R - 1))) >>> SH_R;
    return p <<< SH_L;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -longint'(64'h80000000)) return 32'h80000000;
    return v[31:0];
  endfunction

  // Expands one segment into its two triangles and queues the vertices.
  function automatic void expand_segment(logic [127:0] seg);
    longint x[2], z[2], dx, dz, ox, oz, vx[4], vz[4];
    longint unsigned ax, az, m, len, ox_mag, oz_mag;
    longint unsigned top;
    int order[6];
    vertex_t v;
    order = '{0, 1, 2, 1, 3, 2};
    top = 64'd1 << NB;
    x[0] = to_world_units(seg[31:0], ctr_lon, scale);
    z[0] = -to_world_units(seg[63:32], ctr_lat, scale);
    x[1] = to_world_units(seg[95:64], ctr_lon, scale);
    z[1] = -to_world_units(seg[127:96], ctr_lat, scale);
    dx = x[1] - x[0];
    dz = z[1] - z[0];
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    // Segments below the minimum length leave no vertices.
    if (ax < top && az < top && ax * ax + az * az <= longint'(LIMIT))
      return;
    m = ax > az ? ax : az;
    while (m >= top) begin
      ax >>= 1; az >>= 1; m >>= 1;
    end
    while (m < (top >> 1)) begin
      ax <<= 1; az <<= 1; m <<= 1;
    end
    len = floor_sqrt(ax * ax + az * az);
    if (len == 0) len = 1;
    ox_mag = (az * half_w + len / 2) / len;
    oz_mag = (ax * half_w + len / 2) / len;
    ox = dz < 0 ? longint'(ox_mag) : -longint'(ox_mag);
    oz = dx < 0 ? -longint'(oz_mag) : longint'(oz_mag);
    vx[0] = x[0] + ox; vz[0] = z[0] + oz;
    vx[1] = x[0] - ox; vz[1] = z[0] - oz;
    vx[2] = x[1] + ox; vz[2] = z[1] + oz;
    vx[3] = x[1] - ox; vz[3] = z[1] - oz;
    for (int k = 0; k < 6; k++) begin
      v.vx = clamp32(vx[order[k]]);
      v.vz = clamp32(vz[order[k]]);
      v.last = (k == 5);
      quad_vertex_q = {quad_vertex_q, v};
    end
  endfunction

  initial fail_count = 0;

  // Register writes, segment transactions and vertex transactions, in that order.
  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst) begin
      ctr_lon = 0;
      ctr_lat = 0;
      scale   = SCALE_RESET;
      half_w  = HALF_WIDTH_RESET;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CENTER_LON: ctr_lon = cfg_data;
          REG_CENTER_LAT: ctr_lat = cfg_data;
          REG_MAP_SCALE:  scale   = cfg_data[15:0];
          REG_HALF_WIDTH: half_w  = cfg_data[23:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expand_segment(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (quad_vertex_q.size() == 0) begin
          $error("unexpected vertex x=%h z=%h", m_axis_tdata[31:0], m_axis_tdata[63:32]);
          fail_count++;
        end else begin
          exp_v = quad_vertex_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_v.vx) begin
            $error("vert_x expected %h actual %h", exp_v.vx, m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[63:32] !== exp_v.vz) begin
            $error("vert_z expected %h actual %h", exp_v.vz, m_axis_tdata[63:32]);
            fail_count++;
          end
          if (m_axis_tlast !== exp_v.last) begin
            $error("last_vertex expected %b actual %b", exp_v.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
    vertices_pending = quad_vertex_q.size();
  end

endmodule
`default_nettype wire

### dv/line_segment_to_quad_test.sv
// Top of the segment-to-quad testbench: clock, reset, segment stimulus and verdict.
// Depends on lsq_pkg, line_segment_to_quad and lsq_checker.
`default_nettype none
module line_segment_to_quad_test;
  import lsq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = REG_CENTER_LON;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count, vertices_pending;
  int           cycle_count = 0;
  bit           steady = 1'b0;

  line_segment_to_quad u_dut (.*);
  lsq_checker u_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, none while running steady.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = gap_length();
      m_axis_tready = (stall == 0);
      repeat (stall) @(negedge clk);
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_segment(logic [31:0] lon1, logic [31:0] lat1,
                              logic [31:0] lon2, logic [31:0] lat2);
    repeat (gap_length()) @(negedge clk);
    s_axis_tdata = {lat2, lon2, lat1, lon1};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Lets every queued vertex drain, then covers any dropped segment still in flight.
  task automatic wait_quiet();
    while (vertices_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic configure(logic [31:0] lon, logic [31:0] lat, logic [15:0] sc,
                           logic [23:0] hw);
    wait_quiet();
    write_reg(REG_CENTER_LON, lon);
    write_reg(REG_CENTER_LAT, lat);
    write_reg(REG_MAP_SCALE, {16'd0, sc});
    write_reg(REG_HALF_WIDTH, {8'd0, hw});
  endtask

  // Random segment: mostly short streets near the centre, some fully random.
  task automatic random_segment(logic [31:0] lon0, logic [31:0] lat0);
    logic [31:0] a, b;
    int spread;
    if ($urandom_range(0, 3) == 0) begin
      send_segment($urandom, $urandom, $urandom, $urandom);
    end else begin
      spread = 1 << $urandom_range(0, 20);
      a = lon0 + $urandom_range(0, 2 * spread) - spread;
      b = lat0 + $urandom_range(0, 2 * spread) - spread;
      send_segment(a, b, a + $urandom_range(0, 2 * spread) - spread,
                   b + $urandom_range(0, 2 * spread) - spread);
    end
  endtask

  initial begin
    logic [31:0] lon0, lat0;
    logic [15:0] sc;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: degenerate, extreme and axis-aligned segments at reset settings.
    send_segment(0, 0, 0, 0);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_segment(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 0, 1);
    send_segment(100, -200, -300, 400);
    send_segment(32'h7fffffff, 0, 32'h7fffffff, 1);
    send_segment(32'h12345678, 32'hedcba987, 32'h12345678, 32'hedcba987);

    // Unit scale puts the minimum-length threshold within reach.
    configure(0, 0, 16'd1, 24'd65536);
    send_segment(0, 0, 6 * 64, 2 * 64);
    send_segment(0, 0, 6 * 64, 3 * 64);
    send_segment(0, 0, 0, 7 * 64);
    send_segment(0, 0, -(6 * 64), 0);
    send_segment(0, 0, 3 * 64 - 1, 0);
    send_segment(-64, 32, 64, -32);

    // Zero scale collapses everything to a point; widest and zero half widths.
    configure(32'h80000000, 32'h7fffffff, 16'd0, 24'hffffff);
    send_segment(32'h7fffffff, 32'h80000000, 0, 0);
    configure(32'h80000000, 32'h7fffffff, 16'hffff, 24'hffffff);
    send_segment(32'h7fffffff, 32'h80000000, 0, 0);
    send_segment(32'h80000000, 32'h7fffffff, 32'h80000100, 32'h7fffff00);
    configure(32'h7fffffff, 32'h80000000, 16'hffff, 24'd0);
    send_segment(32'h7fffffff, 32'h80000000, 32'h7ffffff0, 32'h80000010);
    send_segment(0, 0, 32'h7fffffff, 32'h80000000);

    // Random phases, each under its own settings; one runs without idling.
    for (int phase = 0; phase < 6; phase++) begin
      lon0 = $urandom;
      lat0 = $urandom;
      case (phase)
        0: sc = 16'd20000;
        1: sc = 16'hffff;
        2: sc = 16'd1;
        default: sc = $urandom_range(1, 65535);
      endcase
      configure(lon0, lat0, sc, (phase == 3) ? 24'hffffff : 24'($urandom));
      steady = (phase == 4);
      for (int n = 0; n < 48; n++) random_segment(lon0, lat0);
      steady = 1'b0;
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
rtl/lsq_pkg.sv
rtl/lsq_sqrt.sv
rtl/lsq_div.sv
rtl/line_segment_to_quad.sv
dv/lsq_checker.sv
dv/line_segment_to_quad_test.sv
